// ===== rtl/sust_pkg.sv =====
// Shared types and constants for the sorted unique set table.
`timescale 1ns / 1ps

package sust_pkg;

  localparam int CAPACITY = 32;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int COUNT_W  = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  typedef struct packed {
    op_t                        opcode;
    logic signed [VALUE_W-1:0]  value;
    logic        [INDEX_W-1:0]  index;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  data;
    logic        [COUNT_W-1:0]  count;
  } rsp_t;

  // RAM read address source
  typedef enum logic [1:0] {
    RD_PTR    = 2'd0,
    RD_PTR_M1 = 2'd1,
    RD_PTR_P1 = 2'd2,
    RD_IDX    = 2'd3
  } rd_sel_t;

  // RAM write address and data source
  typedef enum logic {
    WR_PTR_RD  = 1'b0,
    WR_POS_VAL = 1'b1
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    ptr_inc;
    logic    ptr_dec;
    logic    ptr_idx;
    logic    set_pos;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    finish;
    status_t status;
    logic    take_data;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_ok;
    logic full;
    logic ptr_at_count;
    logic ptr_p1_at_count;
    logic ptr_at_pos;
    logic ge;
    logic eq;
  } stat_t;

endpackage

// ===== rtl/sust_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sust_datapath.sv =====
// Datapath: entry count, pointers, captured item, entry RAM and result register.
`timescale 1ns / 1ps

module sust_datapath #(
  parameter int CAPACITY = sust_pkg::CAPACITY
) (
  input  logic            clk,
  input  logic            rst,
  input  sust_pkg::req_t  request,
  input  sust_pkg::cmd_t  cmd,
  output sust_pkg::stat_t stat,
  output sust_pkg::rsp_t  response,
  output logic            response_valid
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > sust_pkg::INDEX_W) ? CW : sust_pkg::INDEX_W;

  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic [CW-1:0]                      ptr;
  logic [CW-1:0]                      pos;
  sust_pkg::op_t                      op_r;
  logic signed [sust_pkg::VALUE_W-1:0] val_r;
  logic [sust_pkg::INDEX_W-1:0]       idx_r;

  logic [CW-1:0]                 ptr_m1;
  logic [CW-1:0]                 ptr_p1;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [sust_pkg::VALUE_W-1:0]  rd_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [sust_pkg::VALUE_W-1:0]  wr_data;

  assign ptr_m1 = ptr - CW'(1);
  assign ptr_p1 = ptr + CW'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      sust_pkg::RD_PTR:    rd_addr = ptr[AW-1:0];
      sust_pkg::RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
      sust_pkg::RD_PTR_P1: rd_addr = ptr_p1[AW-1:0];
      sust_pkg::RD_IDX:    rd_addr = AW'(idx_r);
      default:             rd_addr = ptr[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      sust_pkg::WR_PTR_RD: begin
        wr_addr = ptr[AW-1:0];
        wr_data = rd_data;
      end
      sust_pkg::WR_POS_VAL: begin
        wr_addr = pos[AW-1:0];
        wr_data = val_r;
      end
      default: begin
        wr_addr = ptr[AW-1:0];
        wr_data = rd_data;
      end
    endcase
  end

  assign rd_en = cmd.rd_en;
  assign wr_en = cmd.wr_en;

  sust_ram #(
    .WIDTH (sust_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    priority if (cmd.cnt_clr) begin
      count_next = '0;
    end else if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      response_valid <= 1'b0;
    end else begin
      count          <= count_next;
      response_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= request.opcode;
      val_r <= request.value;
      idx_r <= request.index;
      ptr   <= '0;
    end else if (cmd.set_pos) begin
      pos <= ptr;
      ptr <= count;
    end else if (cmd.ptr_idx) begin
      ptr <= CW'(idx_r);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_p1;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_m1;
    end
    if (cmd.finish) begin
      response.status <= cmd.status;
      response.data   <= cmd.take_data ? $signed(rd_data) : '0;
      response.count  <= sust_pkg::COUNT_W'(count_next);
    end
  end

  assign stat.op              = op_r;
  assign stat.idx_ok          = XW'(idx_r) < XW'(count);
  assign stat.full            = count == CW'(CAPACITY);
  assign stat.ptr_at_count    = ptr == count;
  assign stat.ptr_p1_at_count = ptr_p1 == count;
  assign stat.ptr_at_pos      = ptr == pos;
  assign stat.ge              = $signed(rd_data) >= val_r;
  assign stat.eq              = $signed(rd_data) == val_r;

endmodule

// ===== rtl/sust_ctrl.sv =====
// Controller: sequences search, shift, remove, read and clear over the datapath.
`timescale 1ns / 1ps

module sust_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  sust_pkg::stat_t stat,
  output sust_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [3:0] {
    IDLE,
    DECODE,
    INS_SRCH,
    INS_CHK,
    SHF_RD,
    SHF_WR,
    DEL_RD,
    DEL_WR,
    RD_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != IDLE;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = sust_pkg::RD_PTR;
    cmd.wr_sel = sust_pkg::WR_PTR_RD;
    cmd.status = sust_pkg::ST_DONE;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        unique case (stat.op)
          sust_pkg::OP_INSERT: state_next = INS_SRCH;
          sust_pkg::OP_REMOVE: begin
            if (stat.idx_ok) begin
              cmd.ptr_idx = 1'b1;
              state_next  = DEL_RD;
            end else begin
              cmd.finish = 1'b1;
              cmd.status = sust_pkg::ST_RANGE;
              state_next = IDLE;
            end
          end
          sust_pkg::OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.finish  = 1'b1;
            state_next  = IDLE;
          end
          sust_pkg::OP_READ: begin
            if (stat.idx_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = sust_pkg::RD_IDX;
              state_next = RD_WAIT;
            end else begin
              cmd.finish = 1'b1;
              cmd.status = sust_pkg::ST_RANGE;
              state_next = IDLE;
            end
          end
          default: state_next = IDLE;
        endcase
      end
      INS_SRCH: begin
        // no entry at or above the value: append at the end unless full
        if (stat.ptr_at_count) begin
          if (stat.full) begin
            cmd.finish = 1'b1;
            cmd.status = sust_pkg::ST_FULL;
            state_next = IDLE;
          end else begin
            cmd.set_pos = 1'b1;
            state_next  = SHF_RD;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = INS_CHK;
        end
      end
      INS_CHK: begin
        priority if (!stat.ge) begin
          cmd.ptr_inc = 1'b1;
          state_next  = INS_SRCH;
        end else if (stat.eq) begin
          cmd.finish = 1'b1;
          cmd.status = sust_pkg::ST_DUPLICATE;
          state_next = IDLE;
        end else if (stat.full) begin
          cmd.finish = 1'b1;
          cmd.status = sust_pkg::ST_FULL;
          state_next = IDLE;
        end else begin
          cmd.set_pos = 1'b1;
          state_next  = SHF_RD;
        end
      end
      SHF_RD: begin
        // gap reached the insert position: drop the value in
        if (stat.ptr_at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = sust_pkg::WR_POS_VAL;
          cmd.cnt_inc = 1'b1;
          cmd.finish  = 1'b1;
          cmd.status  = sust_pkg::ST_INSERTED;
          state_next  = IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sust_pkg::RD_PTR_M1;
          state_next = SHF_WR;
        end
      end
      SHF_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_dec = 1'b1;
        state_next  = SHF_RD;
      end
      DEL_RD: begin
        if (stat.ptr_p1_at_count) begin
          cmd.cnt_dec = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sust_pkg::RD_PTR_P1;
          state_next = DEL_WR;
        end
      end
      DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_next  = DEL_RD;
      end
      RD_WAIT: begin
        cmd.take_data = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

// ===== rtl/sorted_unique_set_table.sv =====
// Top level of the sorted unique set table.
`timescale 1ns / 1ps

// Holds up to CAPACITY distinct signed 32-bit values in ascending order in a
// single-port-write, registered-read RAM. Issue an item by raising start
// while busy is low; the item is taken at that clock edge. Exactly one result
// comes back per item on response, marked by response_valid for a single
// cycle; it cannot be held off, so capture it when the strobe is high. busy
// drops in the cycle the result is shown, so the next item may be issued
// then. Each entry searched is read from the RAM and then compared, and each
// entry moved is read and then written. Insert runs a linear search up to the
// insert point, then a shift of the entries above it; remove shifts the
// entries above the index down. Out-of-range removes and reads return without
// touching the RAM.
module sorted_unique_set_table #(
  parameter int CAPACITY = sust_pkg::CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sust_pkg::req_t request,
  output logic           busy,
  output sust_pkg::rsp_t response,
  output logic           response_valid
);

  sust_pkg::cmd_t  cmd;
  sust_pkg::stat_t stat;

  sust_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sust_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .cmd            (cmd),
    .stat           (stat),
    .response       (response),
    .response_valid (response_valid)
  );

endmodule
